@@ hw/rtl/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants and types for the two-wire command sender.
// ----------------------------------------------------------------------------
package tws_pkg;

    // command length and counter widths
    localparam int CMD_BITS   = 16;
    localparam int BIT_CNT_W  = $clog2(CMD_BITS + 1);
    localparam int SHORT_W    = 16;
    localparam int LONG_W     = 24;
    localparam int WAIT_W     = LONG_W;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int OUT_DATA_W = 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SETTLE = 8'd3;

    // register reset values
    localparam logic [SHORT_W-1:0] START_LOW_RST    = 16'd5900;
    localparam logic [SHORT_W-1:0] HALF_BIT_RST     = 16'd220;
    localparam logic [LONG_W-1:0]  RESET_LOW_RST    = 24'd302600;
    localparam logic [LONG_W-1:0]  RESET_SETTLE_RST = 24'd1506600;

    // sequencer phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_RST_LOW    = 3'd1;
    localparam logic [2:0] PH_RST_SETTLE = 3'd2;
    localparam logic [2:0] PH_START_LOW  = 3'd3;
    localparam logic [2:0] PH_HALF_ONE   = 3'd4;
    localparam logic [2:0] PH_HALF_TWO   = 3'd5;

    typedef struct packed {
        logic [SHORT_W-1:0] start_low_ticks;
        logic [SHORT_W-1:0] half_bit_ticks;
        logic [LONG_W-1:0]  reset_low_ticks;
        logic [LONG_W-1:0]  reset_settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic refused;
        logic busy_res;
        logic reset_line;
        logic data_line;
        logic clock_line;
    } result_t;

endpackage

@@ hw/rtl/tws_seq.sv @@
// ----------------------------------------------------------------------------
// tws_seq
// Tick sequencer: countdown, bit shifter and line levels, one step per tick.
// ----------------------------------------------------------------------------
module tws_seq
    import tws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [ACTION_W-1:0] action,
    input  logic [CMD_BITS-1:0] command_word,
    input  cfg_t                cfg,
    output result_t             result
);

    logic [2:0]           phase_reg, phase_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    logic [CMD_BITS-1:0]  shift_reg, shift_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 clock_reg, clock_next;
    logic                 data_reg, data_next;
    logic                 reset_reg, reset_next;
    logic                 refused;

    // zero interval counts as one tick
    function automatic logic [WAIT_W-1:0] at_least_one(input logic [WAIT_W-1:0] v);
        at_least_one = (v == '0) ? WAIT_W'(1) : v;
    endfunction

    // countdown, phase transition, then request intake
    always_comb
    begin
        logic [WAIT_W-1:0] wait_dec;
        wait_dec     = (wait_reg != '0) ? wait_reg - WAIT_W'(1) : '0;
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        clock_next   = clock_reg;
        data_next    = data_reg;
        reset_next   = reset_reg;
        refused      = 1'b0;

        if (phase_reg != PH_IDLE)
        begin
            wait_next = wait_dec;
            if (wait_dec == '0)
            begin
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        reset_next = 1'b1;
                        phase_next = PH_RST_SETTLE;
                        wait_next  = at_least_one(cfg.reset_settle_ticks);
                    end
                    PH_START_LOW:
                    begin
                        phase_next = PH_HALF_ONE;
                        wait_next  = at_least_one(WAIT_W'(cfg.half_bit_ticks));
                    end
                    PH_HALF_ONE:
                    begin
                        clock_next = 1'b0;
                        data_next  = shift_reg[CMD_BITS-1];
                        phase_next = PH_HALF_TWO;
                        wait_next  = at_least_one(WAIT_W'(cfg.half_bit_ticks));
                    end
                    PH_HALF_TWO:
                    begin
                        clock_next   = 1'b1;
                        shift_next   = shift_reg << 1;
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        if (bit_cnt_next >= BIT_CNT_W'(CMD_BITS))
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_HALF_ONE;
                            wait_next  = at_least_one(WAIT_W'(cfg.half_bit_ticks));
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        // requests only start from idle, otherwise flagged
        if (action inside {ACT_SEND, ACT_RESET})
        begin
            if (phase_next != PH_IDLE)
            begin
                refused = 1'b1;
            end
            else if (action == ACT_SEND)
            begin
                clock_next   = 1'b0;
                shift_next   = command_word;
                bit_cnt_next = '0;
                phase_next   = PH_START_LOW;
                wait_next    = at_least_one(WAIT_W'(cfg.start_low_ticks));
            end
            else
            begin
                reset_next = 1'b0;
                phase_next = PH_RST_LOW;
                wait_next  = at_least_one(cfg.reset_low_ticks);
            end
        end
    end

    // levels after this tick
    assign result.clock_line = clock_next;
    assign result.data_line  = data_next;
    assign result.reset_line = reset_next;
    assign result.busy_res   = (phase_next != PH_IDLE);
    assign result.refused    = refused;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            wait_reg    <= '0;
            shift_reg   <= '0;
            bit_cnt_reg <= '0;
            clock_reg   <= 1'b1;
            data_reg    <= 1'b0;
            reset_reg   <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            wait_reg    <= wait_next;
            shift_reg   <= shift_next;
            bit_cnt_reg <= bit_cnt_next;
            clock_reg   <= clock_next;
            data_reg    <= data_next;
            reset_reg   <= reset_next;
        end
    end

endmodule

@@ hw/rtl/two_wire_command_sender.sv @@
// ----------------------------------------------------------------------------
// two_wire_command_sender
// Clock, data and reset line driver for a serial sound module.
// ----------------------------------------------------------------------------
// Every accepted input transfer is one tick: the sequencer counts down its
// running interval, makes any due transition and takes a send or reset
// request if idle, all combinationally, and the line levels after that
// tick are placed in the output register as one result transfer. A new tick
// is taken every cycle as long as the output register is empty or drained in
// the same cycle, so the sustained rate is one item per clock; the result is
// registered and valid in the cycle after the input transfer. Requests that arrive
// while a sequence runs are dropped and flagged in the refused bit. Intervals
// are counted in ticks, and a zero interval register acts as one tick.
module two_wire_command_sender
    import tws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick / request input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CMD_BITS-1:0]   s_tdata,   // [15:0] command_word
    input  logic [ACTION_W-1:0]   s_tuser,   // [1:0] action
    // line level results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] clock_line, [1] data_line, [2] reset_line, [3] busy_res, [4] refused
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LONG_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    result_t step_res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    in_xfer;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks    <= START_LOW_RST;
            cfg_reg.half_bit_ticks     <= HALF_BIT_RST;
            cfg_reg.reset_low_ticks    <= RESET_LOW_RST;
            cfg_reg.reset_settle_ticks <= RESET_SETTLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_LOW:    cfg_reg.start_low_ticks    <= cfg_data[SHORT_W-1:0];
                REG_HALF_BIT:     cfg_reg.half_bit_ticks     <= cfg_data[SHORT_W-1:0];
                REG_RESET_LOW:    cfg_reg.reset_low_ticks    <= cfg_data;
                REG_RESET_SETTLE: cfg_reg.reset_settle_ticks <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input side accepts whenever the output register frees up
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    tws_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_xfer),
        .action       (s_tuser),
        .command_word (s_tdata),
        .cfg          (cfg_reg),
        .result       (step_res)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_reg};

`ifndef NO_ASSERTIONS
    // a dropped request only happens while a sequence runs
    a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("refused result without busy");

    // reset line is only low inside a reset sequence
    a_reset_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[3])
        else $error("reset line low while not busy");

    // the input side never stalls while the output register is empty
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // an input transfer always yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transfer produced no result");
`endif

endmodule
